/* hw/rtl/rlp_pkg.sv */
// Shared types and constants for the list element parser.
package rlp_pkg;

  localparam int unsigned BUF_BYTES_DEF = 65536;

  // Result queue depth (power of two).
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PW    = $clog2(RES_DEPTH);

  // Configuration register indexes.
  localparam logic CFG_IDX_MAX_ITEMS = 1'b0;
  localparam logic [7:0] MAX_ITEMS_RST = 8'd16;

  // Header byte boundaries.
  localparam logic [7:0] HDR_SINGLE_MAX = 8'h80;
  localparam logic [7:0] HDR_LIST_BASE  = 8'hc0;
  localparam logic [5:0] HDR_SHORT_MAX  = 6'h37;

  localparam logic KIND_DESC   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] TY_SINGLE = 2'd0;
  localparam logic [1:0] TY_STRING = 2'd1;
  localparam logic [1:0] TY_LIST   = 2'd2;

  typedef enum logic [2:0] {
    PH_OUTER_HDR = 3'd0,
    PH_OUTER_LEN = 3'd1,
    PH_ELEM_HDR  = 3'd2,
    PH_ELEM_LEN  = 3'd3,
    PH_PAYLOAD   = 3'd4,
    PH_SKIP      = 3'd5,
    PH_FAIL      = 3'd6
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  elem_index;
    logic [1:0]  elem_type;
    logic [7:0]  elem_value;
    logic [16:0] elem_length;
    logic [15:0] elem_offset;
    logic        parse_ok;
    logic [7:0]  elem_count;
    logic        run_last;
  } res_t;

  // Results produced by one byte, handed to the queue.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [RES_PW:0] level;
    logic            room2;
  } fifo_stat_t;

endpackage

/* hw/rtl/rlp_core.sv */
// Input register, parser state and per-byte header decode.
module rlp_core import rlp_pkg::*; #(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic [7:0] max_items_i,
  input  fifo_stat_t fifo_stat_i,
  output push_t      push_o
);

  localparam int unsigned PW = $clog2(BUF_BYTES + 2);
  localparam logic [PW-1:0] BufMax = PW'(BUF_BYTES);
  localparam logic [PW-1:0] Cap    = PW'(BUF_BYTES + 1);

  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          in_last_q;
  logic          proc;

  phase_e        phase_q, phase_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] oe_q, oe_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [3:0]    lbl_q, lbl_d;
  logic [1:0]    ctype_q, ctype_d;
  logic [PW-1:0] pay_q, pay_d;
  logic [7:0]    cnt_q, cnt_d;

  logic [PW-1:0] np;
  logic [PW-1:0] acc_new;
  logic [PW+7:0] acc_wide;
  logic [5:0]    t;
  logic          is_short;
  logic [3:0]    lnum;
  logic [PW:0]   oe_sum;
  logic [PW:0]   end_sum;
  logic          fin_go;
  logic [PW-1:0] fin_len;
  logic [1:0]    fin_type;
  logic [PW-1:0] rep;
  logic          desc_v;
  res_t          desc;
  res_t          stat;

  assign proc       = in_valid_q && fifo_stat_i.room2;
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OUTER_HDR;
      pos_q   <= '0;
      oe_q    <= '0;
      acc_q   <= '0;
      lbl_q   <= '0;
      ctype_q <= '0;
      pay_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      oe_q    <= oe_d;
      acc_q   <= acc_d;
      lbl_q   <= lbl_d;
      ctype_q <= ctype_d;
      pay_q   <= pay_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    oe_d     = oe_q;
    acc_d    = acc_q;
    lbl_d    = lbl_q;
    ctype_d  = ctype_q;
    pay_d    = pay_q;
    cnt_d    = cnt_q;
    oe_sum   = '0;
    end_sum  = '0;
    fin_go   = 1'b0;
    fin_len  = '0;
    fin_type = ctype_q;
    rep      = '0;
    desc_v   = 1'b0;
    desc     = '0;
    stat     = '0;
    push_o   = '0;

    np = (pos_q >= BufMax) ? BufMax : pos_q + 1'b1;

    // Saturating big-endian length accumulation.
    acc_wide = {acc_q, in_byte_q};
    if (acc_q >= Cap || acc_wide > {8'd0, Cap}) begin
      acc_new = Cap;
    end else begin
      acc_new = acc_wide[PW-1:0];
    end

    t        = in_byte_q[5:0];
    is_short = (t <= HDR_SHORT_MAX);
    lnum     = 4'(t - HDR_SHORT_MAX);

    if (proc) begin
      unique case (phase_q)
        PH_OUTER_HDR: begin
          if (in_byte_q < HDR_LIST_BASE) begin
            phase_d = PH_FAIL;
          end else if (is_short) begin
            oe_d    = PW'(t) + 1'b1;
            phase_d = PH_ELEM_HDR;
          end else begin
            acc_d   = '0;
            lbl_d   = lnum;
            phase_d = PH_OUTER_LEN;
          end
        end
        PH_OUTER_LEN: begin
          acc_d = acc_new;
          lbl_d = lbl_q - 1'b1;
          if (lbl_q == 4'd1) begin
            oe_sum = {1'b0, np} + {1'b0, acc_new};
            oe_d   = oe_sum[PW-1:0];
            if (acc_new > BufMax || oe_sum > {1'b0, BufMax}) begin
              phase_d = PH_FAIL;
            end else begin
              phase_d = PH_ELEM_HDR;
            end
          end
        end
        PH_ELEM_HDR: begin
          if (pos_q >= oe_q) begin
            phase_d = PH_FAIL;
          end else if (cnt_q >= max_items_i) begin
            phase_d = PH_SKIP;
          end else if (in_byte_q <= HDR_SINGLE_MAX) begin
            desc_v           = 1'b1;
            desc.kind        = KIND_DESC;
            desc.elem_index  = cnt_q;
            desc.elem_type   = TY_SINGLE;
            desc.elem_value  = (in_byte_q == HDR_SINGLE_MAX) ? 8'd0 : in_byte_q;
            desc.elem_length = 17'd1;
            desc.elem_offset = 16'(pos_q);
            cnt_d            = cnt_q + 1'b1;
          end else begin
            fin_type = (in_byte_q < HDR_LIST_BASE) ? TY_STRING : TY_LIST;
            ctype_d  = fin_type;
            if (is_short) begin
              fin_go  = 1'b1;
              fin_len = PW'(t);
            end else begin
              acc_d   = '0;
              lbl_d   = lnum;
              phase_d = PH_ELEM_LEN;
            end
          end
        end
        PH_ELEM_LEN: begin
          if (pos_q >= oe_q) begin
            phase_d = PH_FAIL;
          end else begin
            acc_d = acc_new;
            lbl_d = lbl_q - 1'b1;
            if (lbl_q == 4'd1) begin
              fin_go  = 1'b1;
              fin_len = acc_new;
            end
          end
        end
        PH_PAYLOAD: begin
          pay_d = pay_q - 1'b1;
          if (pay_q == PW'(1)) begin
            phase_d = PH_ELEM_HDR;
          end
        end
        PH_SKIP: begin
          if (pos_q >= oe_q) begin
            phase_d = PH_FAIL;
          end
        end
        PH_FAIL: begin
          phase_d = PH_FAIL;
        end
        default: begin
          phase_d = PH_FAIL;
        end
      endcase

      // Report a multi-byte element and set up the payload skip.
      if (fin_go) begin
        rep              = (fin_len > BufMax) ? BufMax : fin_len;
        desc_v           = 1'b1;
        desc.kind        = KIND_DESC;
        desc.elem_index  = cnt_q;
        desc.elem_type   = fin_type;
        desc.elem_length = 17'(rep);
        desc.elem_offset = 16'(np);
        cnt_d            = cnt_q + 1'b1;
        end_sum          = {1'b0, np} + {1'b0, fin_len};
        if (fin_len > BufMax || end_sum > {1'b0, oe_q}) begin
          phase_d = PH_FAIL;
        end else if (fin_len != '0) begin
          pay_d   = fin_len;
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d = PH_ELEM_HDR;
        end
      end

      pos_d = np;

      if (in_last_q) begin
        stat.kind       = KIND_STATUS;
        stat.parse_ok   = (phase_d == PH_ELEM_HDR || phase_d == PH_SKIP) && (np == oe_d);
        stat.elem_count = cnt_d;
        stat.run_last   = 1'b1;
        // Start the next buffer from a clean state.
        phase_d = PH_OUTER_HDR;
        pos_d   = '0;
        oe_d    = '0;
        acc_d   = '0;
        lbl_d   = '0;
        ctype_d = '0;
        pay_d   = '0;
        cnt_d   = '0;
      end

      if (desc_v && in_last_q) begin
        push_o.cnt = 2'd2;
        push_o.r0  = desc;
        push_o.r1  = stat;
      end else if (desc_v) begin
        push_o.cnt         = 2'd1;
        push_o.r0          = desc;
        push_o.r0.run_last = 1'b1;
      end else if (in_last_q) begin
        push_o.cnt = 2'd1;
        push_o.r0  = stat;
      end
    end
  end

endmodule

/* hw/rtl/rlp_res_fifo.sv */
// Result queue that takes up to two results a cycle and hands out one.
module rlp_res_fifo import rlp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_res_o,
  output fifo_stat_t stat_o
);

  res_t              mem_q [RES_DEPTH];
  logic [RES_PW-1:0] wr_q;
  logic [RES_PW-1:0] rd_q;
  logic [RES_PW:0]   level_q;
  logic              pop;

  assign out_valid_o  = (level_q != '0);
  assign out_res_o    = mem_q[rd_q];
  assign pop          = out_valid_o && out_ready_i;
  assign stat_o.level = level_q;
  assign stat_o.room2 = (level_q <= (RES_PW+1)'(RES_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + 1'b1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_q + RES_PW'(push_i.cnt);
      rd_q    <= rd_q + RES_PW'(pop);
      level_q <= level_q + (RES_PW+1)'(push_i.cnt) - (RES_PW+1)'(pop);
    end
  end

endmodule

/* hw/rtl/rlp_list_element_parser.sv */
// Streaming parser of the element headers inside an outer RLP list.
// The buffer arrives one byte per transfer, tlast on its final byte, and
// the block takes one byte every cycle while the queue has room. Each byte
// runs through a single registered decode step (input register, header
// decode with length and bound compares, parser state update) and its
// results land in a four-entry result queue that drains one result per
// cycle while the sink is ready. A byte makes at most two results: an
// element descriptor and, on the final byte, the status. The input stalls
// only while the queue has fewer than two free entries, so with a ready
// sink the rate is one byte per cycle. max_items is to be written over
// APB at address 0 while the block is idle; the block does not enforce it.
module rlp_list_element_parser import rlp_pkg::*; #(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] in_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] elem_index, [9:8] elem_type, [17:10] elem_value,
  // [34:18] elem_length, [50:35] elem_offset, [51] parse_ok,
  // [59:52] elem_count, [63:60] zero
  output logic [63:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,  // [0] kind
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [7:0] max_items_q;
  logic       cfg_wr;
  logic       hit_max;
  fifo_stat_t fifo_stat;
  push_t      push;
  res_t       head;

  assign pready_o = 1'b1;
  assign hit_max  = (paddr_i[2] == CFG_IDX_MAX_ITEMS);
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign prdata_o = hit_max ? {24'd0, max_items_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_items_q <= MAX_ITEMS_RST;
    end else if (cfg_wr && hit_max) begin
      max_items_q <= pwdata_i[7:0];
    end
  end

  rlp_core #(
    .BUF_BYTES(BUF_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .max_items_i (max_items_q),
    .fifo_stat_i (fifo_stat),
    .push_o      (push)
  );

  rlp_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (head),
    .stat_o      (fifo_stat)
  );

  assign m_axis_tdata_o = {4'd0, head.elem_count, head.parse_ok, head.elem_offset,
                           head.elem_length, head.elem_value, head.elem_type,
                           head.elem_index};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.run_last;

  // The queue never overfills.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.level <= (RES_PW+1)'(RES_DEPTH))
    else $error("result queue overflow");

  // A push never exceeds the room the queue had.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> fifo_stat.room2)
    else $error("push without room");

  // A status result always closes the run of its byte.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_STATUS) |-> m_axis_tlast_o)
    else $error("status without tlast");

  // A register write lands in max_items.
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && hit_max) |=> (max_items_q == $past(pwdata_i[7:0])))
    else $error("max_items write lost");

endmodule
